// File: src/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg: shared types and constants for the color marker finder
// Pixel and result payloads, register indexes and reset values.
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int COORD_OUT_BITS  = 12;
    localparam int LINE_WIDTH_BITS = 13;
    localparam int CHAN_BITS       = 8;
    localparam int COLOR_BITS      = 24;
    localparam int NUM_KEYS        = 4;
    localparam int CFG_INDEX_BITS  = 3;

    typedef logic [COORD_OUT_BITS-1:0]  coord_t;
    typedef logic [CHAN_BITS-1:0]       chan_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic [LINE_WIDTH_BITS-1:0] line_width_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  frame_first;
        logic  frame_last;
    } pixel_t;

    typedef struct packed {
        coord_t marker_a_col;
        coord_t marker_a_row;
        coord_t marker_b_col;
        coord_t marker_b_row;
        coord_t marker_c_col;
        coord_t marker_c_row;
        coord_t marker_d_col;
        coord_t marker_d_row;
        logic [NUM_KEYS-1:0] found_mask;
    } result_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } tolerance_t;

    // Counter control between the top level and the coordinate counter
    typedef struct packed {
        logic advance;
        logic frame_first;
        logic frame_last;
    } count_ctrl_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KEY_COLOR_A     = 3'd0,
        REG_KEY_COLOR_B     = 3'd1,
        REG_KEY_COLOR_C     = 3'd2,
        REG_KEY_COLOR_D     = 3'd3,
        REG_TOLERANCE_RED   = 3'd4,
        REG_TOLERANCE_GREEN = 3'd5,
        REG_TOLERANCE_BLUE  = 3'd6,
        REG_LINE_WIDTH      = 3'd7
    } cfg_reg_t;

    localparam color_t      KEY_A_RESET      = 24'h00CBFF;
    localparam color_t      KEY_B_RESET      = 24'hD000FF;
    localparam color_t      KEY_C_RESET      = 24'hFFE900;
    localparam color_t      KEY_D_RESET      = 24'h00FF00;
    localparam chan_t       TOLERANCE_RESET  = 8'd20;
    localparam line_width_t LINE_WIDTH_RESET = 13'd640;

    localparam coord_t MARKER_COL_RESET [NUM_KEYS] = '{12'd0, 12'd20, 12'd0, 12'd20};
    localparam coord_t MARKER_ROW_RESET [NUM_KEYS] = '{12'd0, 12'd0, 12'd20, 12'd20};

endpackage

// File: src/cmf_key_match.sv
// ----------------------------------------------------------------------------
// cmf_key_match: compare one pixel against one key color
// Match when every channel differs from the key by no more than its tolerance.
// ----------------------------------------------------------------------------
module cmf_key_match
(
    input  cmf_pkg::chan_t      red,
    input  cmf_pkg::chan_t      green,
    input  cmf_pkg::chan_t      blue,
    input  cmf_pkg::color_t     key,
    input  cmf_pkg::tolerance_t tolerance,
    output logic                hit
);

    cmf_pkg::chan_t key_red;
    cmf_pkg::chan_t key_green;
    cmf_pkg::chan_t key_blue;
    cmf_pkg::chan_t diff_red;
    cmf_pkg::chan_t diff_green;
    cmf_pkg::chan_t diff_blue;

    assign key_red   = key[23:16];
    assign key_green = key[15:8];
    assign key_blue  = key[7:0];

    assign diff_red   = (red > key_red)     ? red - key_red     : key_red - red;
    assign diff_green = (green > key_green) ? green - key_green : key_green - green;
    assign diff_blue  = (blue > key_blue)   ? blue - key_blue   : key_blue - blue;

    assign hit = (diff_red <= tolerance.red) && (diff_green <= tolerance.green)
              && (diff_blue <= tolerance.blue);

endmodule

// File: src/cmf_coord_counter.sv
// ----------------------------------------------------------------------------
// cmf_coord_counter: raster column and row counter
// Column wraps at the clamped line width, row saturates at its top value.
// ----------------------------------------------------------------------------
module cmf_coord_counter #(
    parameter int COORD_BITS = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmf_pkg::count_ctrl_t        ctrl,
    input  cmf_pkg::line_width_t        line_width,
    output logic [COORD_BITS-1:0]       col,
    output logic [COORD_BITS-1:0]       row
);

    localparam int CMPW = (COORD_BITS + 1 > cmf_pkg::LINE_WIDTH_BITS)
                        ? COORD_BITS + 1 : cmf_pkg::LINE_WIDTH_BITS;

    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [CMPW-1:0]       span;
    logic [CMPW-1:0]       lw_ext;
    logic [CMPW-1:0]       lw_eff;
    logic [CMPW-1:0]       col_inc;
    logic                  wrap;

    // A frame start puts the current pixel at the origin
    assign col = ctrl.frame_first ? '0 : col_reg;
    assign row = ctrl.frame_first ? '0 : row_reg;

    assign span   = CMPW'(1) << COORD_BITS;
    assign lw_ext = CMPW'(line_width);

    always_comb
    begin
        lw_eff = lw_ext;
        if (lw_ext == '0)
        begin
            lw_eff = CMPW'(1);
        end
        else if (lw_ext > span)
        begin
            lw_eff = span;
        end
    end

    assign col_inc = CMPW'(col) + CMPW'(1);
    assign wrap    = (col_inc >= lw_eff);

    always_comb
    begin
        col_next = col_inc[COORD_BITS-1:0];
        row_next = row;
        if (ctrl.frame_last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (wrap)
        begin
            col_next = '0;
            if (row != '1)
            begin
                row_next = row + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: src/color_marker_finder.sv
// ----------------------------------------------------------------------------
// color_marker_finder: locate four key-colored markers in a pixel stream
// Report: once the result register is free, a frame's last pixel sets it valid.
// Throughput: one pixel per cycle unless a frame's last pixel waits for the result
// register; the pixel and result registers each refill while the next stage drains.
// Reset: keys, tolerances, line width and marker positions return to defaults;
// counters and found flags clear.
// ----------------------------------------------------------------------------
module color_marker_finder #(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  cmf_pkg::pixel_t       pix,
    output logic                  res_valid,
    input  logic                  res_ready,
    output cmf_pkg::result_t      res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cmf_pkg::cfg_reg_t     cfg_index,
    input  cmf_pkg::color_t       cfg_data
);

    localparam int NK = cmf_pkg::NUM_KEYS;

    // configuration
    cmf_pkg::color_t      key_reg [NK];
    cmf_pkg::tolerance_t  tol_reg;
    cmf_pkg::line_width_t line_width_reg;

    // pixel stage
    logic                 pix_valid_reg;
    cmf_pkg::pixel_t      pix_reg;
    logic                 process;
    logic                 res_free;

    // frame state
    logic [NK-1:0]        found_reg;
    logic [NK-1:0]        found_cur;
    logic [NK-1:0]        found_new;
    logic [NK-1:0]        match;
    logic [NK-1:0]        hit;
    cmf_pkg::coord_t      col_reg [NK];
    cmf_pkg::coord_t      row_reg [NK];
    cmf_pkg::coord_t      col_new [NK];
    cmf_pkg::coord_t      row_new [NK];
    logic [COORD_BITS-1:0] cur_col;
    logic [COORD_BITS-1:0] cur_row;
    cmf_pkg::count_ctrl_t count_ctrl;

    // result stage
    logic                 res_valid_reg;
    cmf_pkg::result_t     res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]     <= cmf_pkg::KEY_A_RESET;
            key_reg[1]     <= cmf_pkg::KEY_B_RESET;
            key_reg[2]     <= cmf_pkg::KEY_C_RESET;
            key_reg[3]     <= cmf_pkg::KEY_D_RESET;
            tol_reg.red    <= cmf_pkg::TOLERANCE_RESET;
            tol_reg.green  <= cmf_pkg::TOLERANCE_RESET;
            tol_reg.blue   <= cmf_pkg::TOLERANCE_RESET;
            line_width_reg <= cmf_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cmf_pkg::REG_KEY_COLOR_A:     key_reg[0]     <= cfg_data;
                cmf_pkg::REG_KEY_COLOR_B:     key_reg[1]     <= cfg_data;
                cmf_pkg::REG_KEY_COLOR_C:     key_reg[2]     <= cfg_data;
                cmf_pkg::REG_KEY_COLOR_D:     key_reg[3]     <= cfg_data;
                cmf_pkg::REG_TOLERANCE_RED:   tol_reg.red    <= cfg_data[7:0];
                cmf_pkg::REG_TOLERANCE_GREEN: tol_reg.green  <= cfg_data[7:0];
                cmf_pkg::REG_TOLERANCE_BLUE:  tol_reg.blue   <= cfg_data[7:0];
                cmf_pkg::REG_LINE_WIDTH:
                    line_width_reg <= cfg_data[cmf_pkg::LINE_WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A pixel that closes a frame waits until the result register is free
    assign res_free  = !res_valid_reg || res_ready;
    assign process   = pix_valid_reg && (!pix_reg.frame_last || res_free);
    assign pix_ready = !pix_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            pix_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            pix_reg <= pix;
        end
    end

    assign count_ctrl.advance     = process;
    assign count_ctrl.frame_first = pix_reg.frame_first;
    assign count_ctrl.frame_last  = pix_reg.frame_last;

    cmf_coord_counter #(
        .COORD_BITS (COORD_BITS)
    ) u_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (count_ctrl),
        .line_width (line_width_reg),
        .col        (cur_col),
        .row        (cur_row)
    );

    for (genvar k = 0; k < NK; k++)
    begin : g_key
        cmf_key_match u_match (
            .red       (pix_reg.red),
            .green     (pix_reg.green),
            .blue      (pix_reg.blue),
            .key       (key_reg[k]),
            .tolerance (tol_reg),
            .hit       (match[k])
        );
    end

    assign found_cur = pix_reg.frame_first ? '0 : found_reg;
    assign hit       = match & ~found_cur;
    assign found_new = found_cur | hit;

    always_comb
    begin
        for (int k = 0; k < NK; k++)
        begin
            col_new[k] = hit[k] ? cmf_pkg::coord_t'(cur_col) : col_reg[k];
            row_new[k] = hit[k] ? cmf_pkg::coord_t'(cur_row) : row_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
            for (int k = 0; k < NK; k++)
            begin
                col_reg[k] <= cmf_pkg::MARKER_COL_RESET[k];
                row_reg[k] <= cmf_pkg::MARKER_ROW_RESET[k];
            end
        end
        else if (process)
        begin
            // drop the flags once the frame is reported
            found_reg <= pix_reg.frame_last ? '0 : found_new;
            for (int k = 0; k < NK; k++)
            begin
                col_reg[k] <= col_new[k];
                row_reg[k] <= row_new[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (process && pix_reg.frame_last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && pix_reg.frame_last)
        begin
            res_reg.marker_a_col <= col_new[0];
            res_reg.marker_a_row <= row_new[0];
            res_reg.marker_b_col <= col_new[1];
            res_reg.marker_b_row <= row_new[1];
            res_reg.marker_c_col <= col_new[2];
            res_reg.marker_c_row <= row_new[2];
            res_reg.marker_d_col <= col_new[3];
            res_reg.marker_d_row <= row_new[3];
            res_reg.found_mask   <= found_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
